// ===== rtl/amapwm_pkg.sv =====
// ----------------------------------------------------------------------------
// amapwm_pkg: shared types and constants of the ADC moving average to PWM duty
// Widths, reset values, register indexes and the divider request type.
// ----------------------------------------------------------------------------
package amapwm_pkg;

	// Window store geometry
	localparam int WINDOW_MAX = 64;
	localparam int POS_W      = $clog2(WINDOW_MAX);
	localparam int LEN_W      = 7;

	// Field and arithmetic widths
	localparam int SAMPLE_W  = 12;
	localparam int FLOOR_W   = 11;
	localparam int PERIOD_W  = 16;
	localparam int DUTY_W    = 16;
	localparam int FRAC_W    = 8;
	localparam int SCALED_W  = 28;
	localparam int SUM_W     = 34;
	localparam int PROD_W    = SAMPLE_W + PERIOD_W;
	localparam int DIV_W     = PROD_W + FRAC_W;
	localparam int DIVISOR_W = SAMPLE_W;
	localparam int MEAN_W    = SUM_W - FRAC_W;
	localparam int QMAG_W    = PERIOD_W + FRAC_W;
	localparam int STEP_W    = $clog2(DIV_W + 1);

	// Divider step counts
	localparam logic [STEP_W-1:0] STEPS_SCALE = STEP_W'(DIV_W);
	localparam logic [STEP_W-1:0] STEPS_MEAN  = STEP_W'(MEAN_W);

	// ADC full scale code
	localparam logic [SAMPLE_W-1:0] ADC_FULL = 12'hFFF;

	// Configuration port
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 16;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_WINDOW_LENGTH = 2'd0,
		REG_ADC_FLOOR     = 2'd1,
		REG_PWM_PERIOD    = 2'd2,
		REG_UNUSED        = 2'd3
	} cfg_reg_t;

	// Register reset values
	localparam logic [LEN_W-1:0]    RST_WINDOW_LENGTH = 7'd50;
	localparam logic [FLOOR_W-1:0]  RST_ADC_FLOOR     = 11'd40;
	localparam logic [PERIOD_W-1:0] RST_PWM_PERIOD    = 16'd10000;

	// Divider request
	typedef struct packed {
		logic              start;
		logic [STEP_W-1:0] steps;
	} div_req_t;

endpackage

// ===== rtl/adc_moving_average_to_pwm_duty_top.sv =====
// ----------------------------------------------------------------------------
// adc_moving_average_to_pwm_duty_top: boxcar average of ADC samples to PWM duty
//
// Each accepted ADC item has the floor code subtracted and is scaled by
// pwm_period / (4095 - adc_floor) to a signed value with 8 fraction bits
// (truncated toward zero). The value replaces the oldest entry of a circular
// window held in a 64 x 28 synchronous RAM; a running sum tracks the window
// and the duty is the sum divided by window_length * 256, clamped at zero.
// Unwritten entries count as zero: a valid bit per entry, cleared at reset
// and whenever the effective window length changes, masks stale RAM data,
// so no clearing pass is needed. One item is in work at a time. An item
// goes through these steps in order: multiply, start the shared
// one-bit-per-cycle divider, run it for the scaling and see it finish,
// update the window, run it again for the mean, and load the output
// register; a mean that is zero or negative skips the second division.
// The next item can be accepted from the cycle after a result is loaded,
// so a new sample is not taken before the last one is through. The output
// register holds a finished duty while the next item is accepted; a later
// result that finds it still occupied waits in place and holds off the
// sample input. Configuration writes are always taken (cfg_ready is tied
// high) and must arrive only while the block is idle. Window lengths of 0
// act as 1, above 64 act as 64.
// ----------------------------------------------------------------------------
module adc_moving_average_to_pwm_duty_top (
	input  logic                                   clk,
	input  logic                                   arst_n,
	// Sample channel
	input  logic                                   in_valid,
	output logic                                   in_ready,
	input  logic [amapwm_pkg::SAMPLE_W-1:0]        adc_sample,
	// Duty channel
	output logic                                   out_valid,
	input  logic                                   out_ready,
	output logic [amapwm_pkg::DUTY_W-1:0]          duty,
	// Configuration channel
	input  logic                                   cfg_valid,
	output logic                                   cfg_ready,
	input  logic [amapwm_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [amapwm_pkg::CFG_DATA_W-1:0]      cfg_data
);

	typedef enum logic [6:0] {
		ST_IDLE  = 7'b0000001,
		ST_MUL   = 7'b0000010,
		ST_LOAD1 = 7'b0000100,
		ST_DIV1  = 7'b0001000,
		ST_UPD   = 7'b0010000,
		ST_DIV2  = 7'b0100000,
		ST_OUT   = 7'b1000000
	} state_t;

	state_t state_q;

	// Configuration registers
	logic [amapwm_pkg::LEN_W-1:0]    window_length_q;
	logic [amapwm_pkg::FLOOR_W-1:0]  adc_floor_q;
	logic [amapwm_pkg::PERIOD_W-1:0] pwm_period_q;

	// Window bookkeeping
	logic [amapwm_pkg::WINDOW_MAX-1:0] vld_q;
	logic signed [amapwm_pkg::SUM_W-1:0] sum_q;
	logic [amapwm_pkg::POS_W-1:0]      pos_q;

	// Per item datapath
	logic [amapwm_pkg::SAMPLE_W-1:0]   sample_q;
	logic [amapwm_pkg::PROD_W-1:0]     prod_q;
	logic                              neg_q;
	logic [amapwm_pkg::DUTY_W-1:0]     res_q;
	logic [amapwm_pkg::DUTY_W-1:0]     duty_q;
	logic                              out_valid_q;

	// Combinational nets
	logic                                  cfg_fire;
	logic                                  in_fire;
	logic                                  out_free;
	logic [amapwm_pkg::LEN_W-1:0]          raw_len;
	logic [amapwm_pkg::LEN_W-1:0]          eff_len;
	logic signed [amapwm_pkg::SAMPLE_W:0]  diff;
	logic signed [amapwm_pkg::SAMPLE_W:0]  diff_neg;
	logic [amapwm_pkg::SAMPLE_W-1:0]       mag;
	logic [amapwm_pkg::PROD_W-1:0]         prod_d;
	logic [amapwm_pkg::SAMPLE_W-1:0]       denom;
	logic [amapwm_pkg::POS_W-1:0]          pos_eff;
	logic [amapwm_pkg::LEN_W-1:0]          pos_inc;
	logic [amapwm_pkg::POS_W-1:0]          pos_next;
	logic [amapwm_pkg::SCALED_W-1:0]       qmag;
	logic [amapwm_pkg::SCALED_W-1:0]       scaled;
	logic [amapwm_pkg::SCALED_W-1:0]       old_entry;
	logic [amapwm_pkg::SCALED_W-1:0]       ram_rdata;
	logic signed [amapwm_pkg::SUM_W-1:0]   sum_new;
	logic                                  mean_pos;

	// Divider hookup
	amapwm_pkg::div_req_t                  div_req;
	logic [amapwm_pkg::DIV_W-1:0]          div_dividend;
	logic [amapwm_pkg::DIVISOR_W-1:0]      div_divisor;
	logic                                  div_done;
	logic [amapwm_pkg::DIV_W-1:0]          div_quo;

	assign cfg_ready = 1'b1;
	assign cfg_fire  = cfg_valid && cfg_ready;
	assign in_ready  = (state_q == ST_IDLE);
	assign in_fire   = in_valid && in_ready;
	assign out_free  = !out_valid_q || out_ready;
	assign out_valid = out_valid_q;
	assign duty      = duty_q;

	// Saturate the written window length into 1..WINDOW_MAX
	assign raw_len = cfg_data[amapwm_pkg::LEN_W-1:0];
	always_comb begin
		if (raw_len == '0) begin
			eff_len = amapwm_pkg::LEN_W'(1);
		end else if (raw_len > amapwm_pkg::LEN_W'(amapwm_pkg::WINDOW_MAX)) begin
			eff_len = amapwm_pkg::LEN_W'(amapwm_pkg::WINDOW_MAX);
		end else begin
			eff_len = raw_len;
		end
	end

	// Offset removal and magnitude for the unsigned multiply and divide
	assign diff     = $signed({1'b0, sample_q}) - $signed({2'b00, adc_floor_q});
	assign diff_neg = -diff;
	assign mag      = diff[amapwm_pkg::SAMPLE_W] ? diff_neg[amapwm_pkg::SAMPLE_W-1:0]
	                                             : diff[amapwm_pkg::SAMPLE_W-1:0];
	assign prod_d   = mag * pwm_period_q;
	assign denom    = amapwm_pkg::ADC_FULL - {1'b0, adc_floor_q};

	// Write position, wrapped into the current window
	assign pos_eff  = (amapwm_pkg::LEN_W'(pos_q) >= window_length_q) ? '0 : pos_q;
	assign pos_inc  = amapwm_pkg::LEN_W'(pos_eff) + 1'b1;
	assign pos_next = (pos_inc >= window_length_q) ? '0 : pos_inc[amapwm_pkg::POS_W-1:0];

	// Signed scaled value from the first quotient; truncation toward zero
	// falls out of dividing the magnitude and restoring the sign
	assign qmag   = {{(amapwm_pkg::SCALED_W-amapwm_pkg::QMAG_W){1'b0}},
	                 div_quo[amapwm_pkg::QMAG_W-1:0]};
	assign scaled = neg_q ? -qmag : qmag;

	// An entry never written since the last clear reads as zero
	assign old_entry = vld_q[pos_eff] ? ram_rdata : '0;
	assign sum_new   = sum_q
	                 + $signed({{(amapwm_pkg::SUM_W-amapwm_pkg::SCALED_W){scaled[amapwm_pkg::SCALED_W-1]}},
	                            scaled})
	                 - $signed({{(amapwm_pkg::SUM_W-amapwm_pkg::SCALED_W){old_entry[amapwm_pkg::SCALED_W-1]}},
	                            old_entry});
	assign mean_pos  = (sum_new > 0);

	// Divider request: scaling division from the product, mean from the new sum
	always_comb begin
		div_req.start = 1'b0;
		div_req.steps = amapwm_pkg::STEPS_SCALE;
		div_dividend  = {prod_q, {amapwm_pkg::FRAC_W{1'b0}}};
		div_divisor   = denom;
		if (state_q == ST_LOAD1) begin
			div_req.start = 1'b1;
		end else if (state_q == ST_UPD) begin
			div_req.start = mean_pos;
			div_req.steps = amapwm_pkg::STEPS_MEAN;
			div_dividend  = {sum_new[amapwm_pkg::SUM_W-1:amapwm_pkg::FRAC_W],
			                 {(amapwm_pkg::DIV_W-amapwm_pkg::MEAN_W){1'b0}}};
			div_divisor   = {{(amapwm_pkg::DIVISOR_W-amapwm_pkg::LEN_W){1'b0}}, window_length_q};
		end
	end

	amapwm_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.req      (div_req),
		.dividend (div_dividend),
		.divisor  (div_divisor),
		.done     (div_done),
		.quotient (div_quo)
	);

	// Window store: read the oldest entry once per item, write the new value in its place in UPD
	amapwm_ram #(
		.WIDTH (amapwm_pkg::SCALED_W),
		.DEPTH (amapwm_pkg::WINDOW_MAX)
	) u_window (
		.clk   (clk),
		.we    (state_q == ST_UPD),
		.waddr (pos_eff),
		.wdata (scaled),
		.re    (state_q == ST_MUL),
		.raddr (pos_eff),
		.rdata (ram_rdata)
	);

	// Item datapath registers
	always_ff @(posedge clk) begin
		if (in_fire) begin
			sample_q <= adc_sample;
		end
		if (state_q == ST_MUL) begin
			prod_q <= prod_d;
			neg_q  <= diff[amapwm_pkg::SAMPLE_W];
		end
		if (state_q == ST_UPD && !mean_pos) begin
			res_q <= '0;
		end else if (state_q == ST_DIV2 && div_done) begin
			res_q <= div_quo[amapwm_pkg::DUTY_W-1:0];
		end
		if (state_q == ST_OUT && out_free) begin
			duty_q <= res_q;
		end
	end

	// Control, configuration and window bookkeeping
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q         <= ST_IDLE;
			window_length_q <= amapwm_pkg::RST_WINDOW_LENGTH;
			adc_floor_q     <= amapwm_pkg::RST_ADC_FLOOR;
			pwm_period_q    <= amapwm_pkg::RST_PWM_PERIOD;
			vld_q           <= '0;
			sum_q           <= '0;
			pos_q           <= '0;
			out_valid_q     <= 1'b0;
		end else begin
			// Register writes; a length change empties the window
			if (cfg_fire) begin
				case (cfg_index)
					amapwm_pkg::REG_WINDOW_LENGTH: begin
						if (eff_len != window_length_q) begin
							window_length_q <= eff_len;
							vld_q           <= '0;
							sum_q           <= '0;
							pos_q           <= '0;
						end
					end
					amapwm_pkg::REG_ADC_FLOOR: begin
						adc_floor_q <= cfg_data[amapwm_pkg::FLOOR_W-1:0];
					end
					amapwm_pkg::REG_PWM_PERIOD: begin
						pwm_period_q <= cfg_data[amapwm_pkg::PERIOD_W-1:0];
					end
					default: begin
					end
				endcase
			end

			// Drop the held duty once taken; a new duty loaded in OUT keeps it up
			if (out_valid_q && out_ready && state_q != ST_OUT) begin
				out_valid_q <= 1'b0;
			end

			case (state_q)
				ST_IDLE: begin
					if (in_fire) begin
						state_q <= ST_MUL;
					end
				end
				ST_MUL: begin
					state_q <= ST_LOAD1;
				end
				ST_LOAD1: begin
					state_q <= ST_DIV1;
				end
				ST_DIV1: begin
					if (div_done) begin
						state_q <= ST_UPD;
					end
				end
				ST_UPD: begin
					sum_q          <= sum_new;
					vld_q[pos_eff] <= 1'b1;
					pos_q          <= pos_next;
					state_q        <= mean_pos ? ST_DIV2 : ST_OUT;
				end
				ST_DIV2: begin
					if (div_done) begin
						state_q <= ST_OUT;
					end
				end
				ST_OUT: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						state_q     <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

// ===== rtl/amapwm_ram.sv =====
// ----------------------------------------------------------------------------
// amapwm_ram: generic single-port-write, single-port-read synchronous RAM
// One write and one registered read per cycle.
// ----------------------------------------------------------------------------
module amapwm_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ===== rtl/amapwm_div.sv =====
// ----------------------------------------------------------------------------
// amapwm_div: unsigned restoring divider, one quotient bit per cycle
// Dividend is loaded left-aligned; after the given step count the quotient
// sits in the low bits of the dividend register. Done pulses for one cycle.
// ----------------------------------------------------------------------------
module amapwm_div (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  amapwm_pkg::div_req_t                 req,
	input  logic [amapwm_pkg::DIV_W-1:0]         dividend,
	input  logic [amapwm_pkg::DIVISOR_W-1:0]     divisor,
	output logic                                 done,
	output logic [amapwm_pkg::DIV_W-1:0]         quotient
);

	logic [amapwm_pkg::DIV_W-1:0]       dvd_q;
	logic [amapwm_pkg::DIVISOR_W-1:0]   rem_q;
	logic [amapwm_pkg::DIVISOR_W-1:0]   dsr_q;
	logic [amapwm_pkg::STEP_W-1:0]      cnt_q;
	logic                               busy_q;
	logic                               done_q;
	logic [amapwm_pkg::DIVISOR_W:0]     shift;
	logic [amapwm_pkg::DIVISOR_W:0]     sub;
	logic                               ge;

	assign shift = {rem_q, dvd_q[amapwm_pkg::DIV_W-1]};
	assign sub   = shift - {1'b0, dsr_q};
	assign ge    = shift >= {1'b0, dsr_q};

	// Datapath: no reset needed
	always_ff @(posedge clk) begin
		if (req.start) begin
			dvd_q <= dividend;
			dsr_q <= divisor;
			rem_q <= '0;
		end else if (busy_q) begin
			dvd_q <= {dvd_q[amapwm_pkg::DIV_W-2:0], ge};
			rem_q <= ge ? sub[amapwm_pkg::DIVISOR_W-1:0] : shift[amapwm_pkg::DIVISOR_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				cnt_q  <= req.steps;
				busy_q <= 1'b1;
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == amapwm_pkg::STEP_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	assign done     = done_q;
	assign quotient = dvd_q;

endmodule

// ===== test/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench: self-checking bench for adc_moving_average_to_pwm_duty_top
// Drives ADC items and register writes, predicts every duty with a local
// boxcar model of the window, running sum and scaling, and compares each
// duty item in order. Both channels idle at random; one test holds the duty
// side off for a long stretch so that the sample side stalls.
// ----------------------------------------------------------------------------
module testbench;

	// Cycles with no handshake at all before the run is declared hung
	localparam int WATCHDOG_LIMIT = 3000;
	// Quiet time after the last duty item
	localparam int SETTLE_CYCLES  = 100;
	// Random traffic: phases with fresh register settings each
	localparam int RANDOM_PHASES  = 20;
	localparam int PHASE_ITEMS    = 80;
	// Trailing phases that run without any idling
	localparam int QUIET_PHASES   = 4;
	// Long receiver hold in the back-pressure test
	localparam int LONG_HOLD      = 300;

	logic                              clk = 1'b0;
	logic                              arst_n;
	logic                              in_valid;
	logic                              in_ready;
	logic [amapwm_pkg::SAMPLE_W-1:0]   adc_sample;
	logic                              out_valid;
	logic                              out_ready;
	logic [amapwm_pkg::DUTY_W-1:0]     duty;
	logic                              cfg_valid;
	logic                              cfg_ready;
	amapwm_pkg::cfg_reg_t              cfg_index;
	logic [amapwm_pkg::CFG_DATA_W-1:0] cfg_data;

	// Idling controls shared between the stimulus and the duty receiver
	bit          tx_idle_enable = 1'b0;
	bit          rx_idle_enable = 1'b0;
	int unsigned rx_hold_cycles = 0;

	int mismatch_count = 0;

	// Duty values still owed by the block, oldest first
	logic [amapwm_pkg::DUTY_W-1:0] pending_duty[$];

	// Local copy of the filter state and the register file
	longint                          window_mem[amapwm_pkg::WINDOW_MAX];
	longint                          running_total;
	int unsigned                     wr_pos;
	int unsigned                     avg_len;
	logic [amapwm_pkg::FLOOR_W-1:0]  floor_code;
	logic [amapwm_pkg::PERIOD_W-1:0] period_cnt;

	adc_moving_average_to_pwm_duty_top u_top (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.adc_sample (adc_sample),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.duty       (duty),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data)
	);

	always #5 clk = ~clk;

	// Empty the window: all entries zero, sum zero, write pointer at the start
	function automatic void clear_window();
		foreach (window_mem[i])
			window_mem[i] = 0;
		running_total = 0;
		wr_pos        = 0;
	endfunction

	// Push one sample through the window and return the duty it yields.
	// All arithmetic is done on signed 64-bit values so that the scaling
	// division truncates toward zero for samples below the floor.
	function automatic logic [amapwm_pkg::DUTY_W-1:0] advance_window(
			input logic [amapwm_pkg::SAMPLE_W-1:0] sample);
		longint code, offset, full, span, gain, scaled, divisor, mean;
		code   = longint'(sample);
		offset = longint'(floor_code);
		full   = longint'(amapwm_pkg::ADC_FULL);
		gain   = longint'(period_cnt);
		span   = full - offset;
		scaled = ((code - offset) * gain * 256) / span;
		// Replace the oldest entry and keep the sum exact
		if (wr_pos >= avg_len)
			wr_pos = 0;
		running_total += scaled - window_mem[wr_pos];
		window_mem[wr_pos] = scaled;
		wr_pos++;
		if (wr_pos >= avg_len)
			wr_pos = 0;
		// Mean over the whole window length; clamp a non-positive sum to zero
		if (running_total > 0) begin
			divisor = longint'(avg_len);
			mean    = running_total / (divisor * 256);
		end else begin
			mean = 0;
		end
		return mean[amapwm_pkg::DUTY_W-1:0];
	endfunction

	// Offer one ADC item, optionally after a random gap, and hold it until
	// taken. Entered and left at a falling edge; valid stays high on return
	// so that a back-to-back item keeps it high without a glitch.
	task automatic offer_sample(input logic [amapwm_pkg::SAMPLE_W-1:0] sample);
		if (tx_idle_enable && $urandom_range(0, 5) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 12)) @(negedge clk);
		end
		in_valid   <= 1'b1;
		adc_sample <= sample;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		pending_duty.push_back(advance_window(sample));
		@(negedge clk);
	endtask

	// Write one register and mirror it into the local register file.
	// Only called while the block is idle.
	task automatic write_register(input amapwm_pkg::cfg_reg_t idx,
			input logic [amapwm_pkg::CFG_DATA_W-1:0] data);
		int unsigned len;
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		case (idx)
			amapwm_pkg::REG_WINDOW_LENGTH: begin
				// Zero acts as one, anything above the store depth as the depth
				len = 32'(data[amapwm_pkg::LEN_W-1:0]);
				if (len == 0)
					len = 1;
				else if (len > amapwm_pkg::WINDOW_MAX)
					len = amapwm_pkg::WINDOW_MAX;
				// Only a change of the effective length empties the window
				if (len != avg_len) begin
					avg_len = len;
					clear_window();
				end
			end
			amapwm_pkg::REG_ADC_FLOOR:  floor_code = data[amapwm_pkg::FLOOR_W-1:0];
			amapwm_pkg::REG_PWM_PERIOD: period_cnt = data[amapwm_pkg::PERIOD_W-1:0];
			default: ;
		endcase
		@(negedge clk);
		cfg_valid <= 1'b0;
		@(negedge clk);
	endtask

	// Drop valid, wait for every owed duty item, then let the block go quiet
	task automatic settle_block();
		in_valid <= 1'b0;
		while (pending_duty.size() != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	// Extremes of the sample range around the reset settings
	task automatic test_reset_defaults();
		tx_idle_enable = 1'b1;
		rx_idle_enable = 1'b1;
		offer_sample(12'h000);
		offer_sample(amapwm_pkg::ADC_FULL);
		offer_sample(12'd40);
		offer_sample(12'd39);
		offer_sample(12'd41);
		offer_sample(12'h800);
		offer_sample(12'hAAA);
		offer_sample(12'h555);
		settle_block();
	endtask

	// Register extremes and the special cases of the length register
	task automatic test_register_extremes();
		// Shortest window, no floor, largest period
		write_register(amapwm_pkg::REG_WINDOW_LENGTH, 16'd1);
		write_register(amapwm_pkg::REG_ADC_FLOOR, 16'd0);
		write_register(amapwm_pkg::REG_PWM_PERIOD, 16'hFFFF);
		offer_sample(amapwm_pkg::ADC_FULL);
		offer_sample(12'h000);
		offer_sample(12'h800);
		settle_block();

		// Highest floor, smallest period: samples below the floor go negative
		write_register(amapwm_pkg::REG_ADC_FLOOR, 16'd2047);
		write_register(amapwm_pkg::REG_PWM_PERIOD, 16'd1);
		offer_sample(12'h000);
		offer_sample(amapwm_pkg::ADC_FULL);
		offer_sample(12'd2047);
		settle_block();

		// Zero period: every duty is zero
		write_register(amapwm_pkg::REG_PWM_PERIOD, 16'd0);
		offer_sample(amapwm_pkg::ADC_FULL);
		settle_block();

		// Length zero acts as one and empties a partly filled window
		write_register(amapwm_pkg::REG_WINDOW_LENGTH, 16'd3);
		write_register(amapwm_pkg::REG_ADC_FLOOR, 16'd100);
		write_register(amapwm_pkg::REG_PWM_PERIOD, 16'd40000);
		offer_sample(amapwm_pkg::ADC_FULL);
		offer_sample(amapwm_pkg::ADC_FULL);
		settle_block();
		write_register(amapwm_pkg::REG_WINDOW_LENGTH, 16'hFF80);
		offer_sample(amapwm_pkg::ADC_FULL);
		settle_block();

		// Oversized length saturates; a second oversized value keeps the window
		write_register(amapwm_pkg::REG_WINDOW_LENGTH, 16'd127);
		offer_sample(amapwm_pkg::ADC_FULL);
		offer_sample(amapwm_pkg::ADC_FULL);
		settle_block();
		write_register(amapwm_pkg::REG_WINDOW_LENGTH, 16'd100);
		offer_sample(amapwm_pkg::ADC_FULL);
		settle_block();

		// Unused register index: nothing changes
		write_register(amapwm_pkg::REG_UNUSED, 16'hFFFF);
		offer_sample(12'h000);
		settle_block();
	endtask

	// Hold the duty side off while items keep coming, so the block fills
	// up and stalls its sample input
	task automatic test_backpressure();
		tx_idle_enable = 1'b0;
		rx_idle_enable = 1'b0;
		write_register(amapwm_pkg::REG_WINDOW_LENGTH, 16'd4);
		write_register(amapwm_pkg::REG_ADC_FLOOR, 16'd40);
		write_register(amapwm_pkg::REG_PWM_PERIOD, 16'd10000);
		rx_hold_cycles = LONG_HOLD;
		repeat (8) offer_sample(12'($urandom_range(0, 4095)));
		settle_block();
	endtask

	// Random settings per phase, random samples with extra weight on the
	// extremes and on codes around the floor
	task automatic test_random_traffic();
		logic [amapwm_pkg::LEN_W-1:0]    raw_len;
		logic [amapwm_pkg::FLOOR_W-1:0]  new_floor;
		logic [amapwm_pkg::PERIOD_W-1:0] new_period;
		logic [amapwm_pkg::SAMPLE_W-1:0] sample;
		for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
			// Idle in the early phases only
			tx_idle_enable = (phase < RANDOM_PHASES - QUIET_PHASES);
			rx_idle_enable = tx_idle_enable;

			case ($urandom_range(0, 5))
				0:       raw_len = 7'd1;
				1:       raw_len = 7'd2;
				2:       raw_len = 7'(amapwm_pkg::WINDOW_MAX);
				3:       raw_len = 7'd0;
				4:       raw_len = 7'($urandom_range(amapwm_pkg::WINDOW_MAX + 1, 127));
				default: raw_len = 7'($urandom_range(1, amapwm_pkg::WINDOW_MAX));
			endcase
			// Now and then rewrite the current length so the window is kept
			if ($urandom_range(0, 3) != 0)
				write_register(amapwm_pkg::REG_WINDOW_LENGTH,
				               {9'($urandom_range(0, 511)), raw_len});
			else
				write_register(amapwm_pkg::REG_WINDOW_LENGTH, 16'(avg_len));

			case ($urandom_range(0, 4))
				0:       new_floor = 11'd0;
				1:       new_floor = 11'd2047;
				default: new_floor = 11'($urandom_range(0, 2047));
			endcase
			if ($urandom_range(0, 4) != 0)
				write_register(amapwm_pkg::REG_ADC_FLOOR,
				               {5'($urandom_range(0, 31)), new_floor});

			case ($urandom_range(0, 7))
				0:       new_period = 16'd0;
				1:       new_period = 16'd1;
				2:       new_period = 16'hFFFF;
				default: new_period = 16'($urandom_range(0, 65535));
			endcase
			if ($urandom_range(0, 4) != 0)
				write_register(amapwm_pkg::REG_PWM_PERIOD, new_period);

			if ($urandom_range(0, 3) == 0)
				write_register(amapwm_pkg::REG_UNUSED, 16'($urandom_range(0, 65535)));

			repeat (PHASE_ITEMS) begin
				case ($urandom_range(0, 7))
					0:       sample = 12'h000;
					1:       sample = amapwm_pkg::ADC_FULL;
					2:       sample = 12'(floor_code) - 12'd1 + 12'($urandom_range(0, 2));
					default: sample = 12'($urandom_range(0, 4095));
				endcase
				offer_sample(sample);
			end
			settle_block();
		end
	endtask

	// Duty receiver: ready changes at the falling edge. A long hold asked
	// by a test takes priority; otherwise stall in random bursts if enabled.
	initial begin : duty_receiver
		int unsigned stall_left;
		stall_left = 0;
		out_ready  = 1'b0;
		forever begin
			@(negedge clk);
			if (rx_hold_cycles != 0) begin
				stall_left     = rx_hold_cycles;
				rx_hold_cycles = 0;
			end else if (stall_left == 0 && rx_idle_enable && $urandom_range(0, 7) == 0) begin
				stall_left = $urandom_range(1, 12);
			end
			if (stall_left != 0) begin
				out_ready <= 1'b0;
				stall_left--;
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	// Compare each accepted duty item with the oldest owed value
	always @(posedge clk) begin : duty_checker
		logic [amapwm_pkg::DUTY_W-1:0] want;
		if (arst_n && out_valid && out_ready) begin
			if (pending_duty.size() == 0) begin
				$display("%0t: duty %0d arrived with none expected", $time, duty);
				mismatch_count++;
			end else begin
				want = pending_duty.pop_front();
				if (duty !== want) begin
					$display("%0t: duty expected %0d, got %0d", $time, want, duty);
					mismatch_count++;
				end
			end
		end
	end

	// End the run if no handshake happens on any channel for too long
	always @(posedge clk) begin : watchdog
		int unsigned quiet_cycles;
		if (!arst_n || (in_valid && in_ready) || (out_valid && out_ready)
				|| (cfg_valid && cfg_ready)) begin
			quiet_cycles = 0;
		end else begin
			quiet_cycles++;
			if (quiet_cycles >= WATCHDOG_LIMIT) begin
				$display("%0t: no progress for %0d cycles", $time, WATCHDOG_LIMIT);
				$display("adc_moving_average_to_pwm_duty_top: mismatch");
				$finish;
			end
		end
	end

	initial begin
		// Known values on every input from time zero; hold reset, then release it
		arst_n     = 1'b0;
		in_valid   = 1'b0;
		adc_sample = '0;
		cfg_valid  = 1'b0;
		cfg_index  = amapwm_pkg::REG_WINDOW_LENGTH;
		cfg_data   = '0;

		avg_len    = 32'(amapwm_pkg::RST_WINDOW_LENGTH);
		floor_code = amapwm_pkg::RST_ADC_FLOOR;
		period_cnt = amapwm_pkg::RST_PWM_PERIOD;
		clear_window();

		repeat (4) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		test_reset_defaults();
		test_register_extremes();
		test_backpressure();
		test_random_traffic();

		if (mismatch_count == 0)
			$display("adc_moving_average_to_pwm_duty_top: match");
		else
			$display("adc_moving_average_to_pwm_duty_top: mismatch");
		$finish;
	end

endmodule

// ===== adc_moving_average_to_pwm_duty_top.f =====
rtl/amapwm_pkg.sv
rtl/amapwm_ram.sv
rtl/amapwm_div.sv
rtl/adc_moving_average_to_pwm_duty_top.sv
test/testbench.sv
